[rtl/integer_to_radix_text_core_macros.svh]
// Assertion helpers for the radix text converter.
`ifndef INTEGER_TO_RADIX_TEXT_CORE_MACROS_SVH
`define INTEGER_TO_RADIX_TEXT_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RIT_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RIT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/rit_pkg.sv]
package rit_pkg;

    localparam int VALUE_W     = 64;
    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 7;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int CHUNK_BITS  = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int DEF_VALUE_BITS = 64;
    localparam int DEF_MAX_DIGITS = 64;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    localparam logic [CFG_DATA_W-1:0] DIGITS_0_3_RESET   = 32'h33323130;
    localparam logic [CFG_DATA_W-1:0] DIGITS_4_7_RESET   = 32'h37363534;
    localparam logic [CFG_DATA_W-1:0] DIGITS_8_11_RESET  = 32'h62613938;
    localparam logic [CFG_DATA_W-1:0] DIGITS_12_15_RESET = 32'h66656463;

    localparam logic [CHAR_W-1:0] ZERO_CHAR = 8'h30;

    localparam logic [CFG_INDEX_W-1:0] CFG_RADIX        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIGITS_0_3   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIGITS_4_7   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIGITS_8_11  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIGITS_12_15 = 3'd4;

    typedef struct packed {
        logic               opcode;
        logic [VALUE_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic              [CHAR_W-1:0] character;
        logic                           minus_before;
        logic                           is_last;
        logic              [LEN_W-1:0]  total_length;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_READ,
        ST_LOAD,
        ST_ZERO
    } state_t;

    typedef logic [3:0][CFG_DATA_W-1:0] digit_table_t;

    function automatic logic [CHAR_W-1:0] char_of(input digit_table_t tbl,
                                                  input logic [DIGIT_W-1:0] d);
        logic [CFG_DATA_W-1:0] word;
        word = tbl[d[3:2]];
        return word[{d[1:0], 3'b000} +: CHAR_W];
    endfunction

endpackage

[rtl/rit_div_step.sv]
// Divide one byte of the dividend by the radix, carrying the running remainder.
module rit_div_step (
    input  logic [rit_pkg::CHUNK_BITS-1:0] chunk,
    input  logic [rit_pkg::DIGIT_W-1:0]    rem_in,
    input  logic [rit_pkg::RADIX_W-1:0]    radix,
    output logic [rit_pkg::CHUNK_BITS-1:0] quot,
    output logic [rit_pkg::DIGIT_W-1:0]    rem_out
);

    always_comb begin
        logic [rit_pkg::DIGIT_W-1:0] rem;
        logic [rit_pkg::RADIX_W-1:0] trial;
        rem  = rem_in;
        quot = '0;
        for (int i = rit_pkg::CHUNK_BITS - 1; i >= 0; i--) begin
            trial = {rem, chunk[i]};
            if (trial >= radix) begin
                quot[i] = 1'b1;
                rem     = rit_pkg::DIGIT_W'(trial - radix);
            end else begin
                rem = trial[rit_pkg::DIGIT_W-1:0];
            end
        end
        rem_out = rem;
    end

endmodule

[rtl/rit_digit_mem.sv]
// Digit store: one write port, one registered read port.
module rit_digit_mem #(
    parameter int DEPTH = rit_pkg::DEF_MAX_DIGITS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [rit_pkg::DIGIT_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [rit_pkg::DIGIT_W-1:0] rd_data
);

    logic [rit_pkg::DIGIT_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/integer_to_radix_text_core.sv]
// Channel  | Ports                          | Payload
// ---------+--------------------------------+-------------------------------------------
// request  | s_valid, s_ready, s_data       | opcode, value
// result   | m_valid, m_ready, m_data       | character, minus_before, is_last, total_length
// config   | cfg_wr_en, cfg_index, cfg_wdata| radix, digits_0_3 .. digits_12_15
//
// One request of D digits takes D divide passes of C = ceil(VALUE_BITS/8) chunks each:
// the shared divide step takes 8 dividend bits per cycle, and each character needs
// one digit store read.
// aresetn is synchronous, active low; the digit store is not cleared.
// A stalled result holds the sequencer; s_ready rises once the last result is loaded.
`include "integer_to_radix_text_core_macros.svh"

module integer_to_radix_text_core #(
    parameter int VALUE_BITS = rit_pkg::DEF_VALUE_BITS,
    parameter int MAX_DIGITS = rit_pkg::DEF_MAX_DIGITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rit_pkg::in_t                        s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rit_pkg::out_t                       m_data,
    input  logic                                cfg_wr_en,
    input  logic [rit_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rit_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int CHUNKS = (VALUE_BITS + rit_pkg::CHUNK_BITS - 1) / rit_pkg::CHUNK_BITS;
    localparam int W      = CHUNKS * rit_pkg::CHUNK_BITS;
    localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int AW     = $clog2(MAX_DIGITS);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

    rit_pkg::state_t state_reg, state_next;

    logic [W-1:0]                    work_reg, work_next;
    logic [rit_pkg::DIGIT_W-1:0]     rem_reg, rem_next;
    logic [CW-1:0]                   chunk_reg, chunk_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [CNT_W-1:0]                emit_reg, emit_next;
    logic                            neg_reg, neg_next;
    logic                            first_reg, first_next;
    logic                            m_valid_reg, m_valid_next;
    rit_pkg::out_t                   m_data_reg, m_data_next;

    logic [rit_pkg::RADIX_W-1:0]     radix_reg;
    rit_pkg::digit_table_t           digits_reg;
    logic [rit_pkg::RADIX_W-1:0]     radix_eff;

    logic [rit_pkg::CHUNK_BITS-1:0]  quot;
    logic [rit_pkg::DIGIT_W-1:0]     rem_out;

    logic                            wr_en, rd_en;
    logic [AW-1:0]                   rd_addr;
    logic [rit_pkg::DIGIT_W-1:0]     rd_data;
    logic [CNT_W-1:0]                emit_minus;

    logic [VALUE_BITS-1:0]           in_value;
    logic                            in_neg;
    logic                            accept;
    logic                            out_free;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg     <= rit_pkg::RADIX_RESET;
            digits_reg[0] <= rit_pkg::DIGITS_0_3_RESET;
            digits_reg[1] <= rit_pkg::DIGITS_4_7_RESET;
            digits_reg[2] <= rit_pkg::DIGITS_8_11_RESET;
            digits_reg[3] <= rit_pkg::DIGITS_12_15_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rit_pkg::CFG_RADIX:        radix_reg     <= cfg_wdata[rit_pkg::RADIX_W-1:0];
                rit_pkg::CFG_DIGITS_0_3:   digits_reg[0] <= cfg_wdata;
                rit_pkg::CFG_DIGITS_4_7:   digits_reg[1] <= cfg_wdata;
                rit_pkg::CFG_DIGITS_8_11:  digits_reg[2] <= cfg_wdata;
                rit_pkg::CFG_DIGITS_12_15: digits_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // saturate the base into 2..16
    always_comb begin
        if (radix_reg < rit_pkg::RADIX_MIN) begin
            radix_eff = rit_pkg::RADIX_MIN;
        end else if (radix_reg > rit_pkg::RADIX_MAX) begin
            radix_eff = rit_pkg::RADIX_MAX;
        end else begin
            radix_eff = radix_reg;
        end
    end

    rit_div_step u_div (
        .chunk   (work_reg[W-1 -: rit_pkg::CHUNK_BITS]),
        .rem_in  (rem_reg),
        .radix   (radix_eff),
        .quot    (quot),
        .rem_out (rem_out)
    );

    rit_digit_mem #(
        .DEPTH (MAX_DIGITS),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (rem_out),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready    = (state_reg == rit_pkg::ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign in_value   = s_data.value[VALUE_BITS-1:0];
    assign in_neg     = s_data.opcode && in_value[VALUE_BITS-1];
    assign emit_minus = emit_reg - 1'b1;
    assign rd_addr    = emit_minus[AW-1:0];

    always_comb begin
        state_next   = state_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        chunk_next   = chunk_reg;
        cnt_next     = cnt_reg;
        emit_next    = emit_reg;
        neg_next     = neg_reg;
        first_next   = first_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        wr_en        = 1'b0;
        rd_en        = 1'b0;

        case (state_reg)
            rit_pkg::ST_IDLE: begin
                if (accept) begin
                    neg_next   = in_neg;
                    work_next  = in_neg ? W'(VALUE_BITS'(~in_value + 1'b1)) : W'(in_value);
                    cnt_next   = '0;
                    state_next = rit_pkg::ST_CHECK;
                end
            end
            rit_pkg::ST_CHECK: begin
                if (work_reg == '0 || cnt_reg == CNT_W'(MAX_DIGITS)) begin
                    if (cnt_reg == '0) begin
                        state_next = rit_pkg::ST_ZERO;
                    end else begin
                        emit_next  = cnt_reg;
                        first_next = 1'b1;
                        state_next = rit_pkg::ST_READ;
                    end
                end else begin
                    rem_next   = '0;
                    chunk_next = '0;
                    state_next = rit_pkg::ST_DIV;
                end
            end
            rit_pkg::ST_DIV: begin
                // shift quotient bits in as dividend bits leave the top
                work_next = W'({work_reg, quot});
                rem_next  = rem_out;
                if (chunk_reg == CW'(CHUNKS - 1)) begin
                    wr_en      = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = rit_pkg::ST_CHECK;
                end else begin
                    chunk_next = chunk_reg + 1'b1;
                end
            end
            rit_pkg::ST_READ: begin
                rd_en      = 1'b1;
                state_next = rit_pkg::ST_LOAD;
            end
            rit_pkg::ST_LOAD: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.character    = rit_pkg::char_of(digits_reg, rd_data);
                    m_data_next.minus_before = first_reg && neg_reg;
                    m_data_next.is_last      = (emit_reg == CNT_W'(1));
                    m_data_next.total_length = (emit_reg == CNT_W'(1))
                        ? rit_pkg::LEN_W'(cnt_reg) + rit_pkg::LEN_W'(neg_reg) : '0;
                    first_next = 1'b0;
                    emit_next  = emit_minus;
                    state_next = (emit_reg == CNT_W'(1)) ? rit_pkg::ST_IDLE : rit_pkg::ST_READ;
                end
            end
            rit_pkg::ST_ZERO: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.character    = rit_pkg::ZERO_CHAR;
                    m_data_next.minus_before = 1'b0;
                    m_data_next.is_last      = 1'b1;
                    m_data_next.total_length = rit_pkg::LEN_W'(1);
                    state_next               = rit_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rit_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rit_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            emit_reg    <= '0;
            chunk_reg   <= '0;
            neg_reg     <= 1'b0;
            first_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            emit_reg    <= emit_next;
            chunk_reg   <= chunk_next;
            neg_reg     <= neg_next;
            first_reg   <= first_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg   <= work_next;
        rem_reg    <= rem_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `RIT_ASSERT_NEXT(a_accept_starts, accept, state_reg == rit_pkg::ST_CHECK, "request not started")
    `RIT_ASSERT_NOW(a_load_has_digit, state_reg == rit_pkg::ST_LOAD, emit_reg != '0, "emit underflow")
    `RIT_ASSERT_NOW(a_len_only_last, m_valid && !m_data.is_last, m_data.total_length == '0, "early length")
    `RIT_ASSERT_NOW(a_last_has_len, m_valid && m_data.is_last, m_data.total_length != '0, "no length")

endmodule
